@@ rtl/core/id3w_pkg.sv @@
// id3w_pkg: shared types, constants and the frame id lookup for the id3v2.4 tag walker
// used by id3w_parser, id3w_fifo and id3v24_tag_frame_walker_unit
// no dependencies
package id3w_pkg;

    localparam int SIZE_BITS      = 28;
    localparam int TYPE_W         = 5;
    localparam int NTYPES         = 19;
    localparam int HDR_LEN        = 10;
    localparam int MIN_FRAME_SIZE = 2;
    localparam int RES_FIFO_DEPTH = 4;

    localparam logic [23:0] TAG_MAGIC     = "ID3";
    localparam logic [7:0]  MAJOR_VERSION = 8'h04;
    localparam logic [7:0]  FLAG_UNSYNC   = 8'h80;
    localparam logic [7:0]  FLAG_EXTHDR   = 8'h40;
    localparam logic [7:0]  FLAG_EXPER    = 8'h20;
    localparam logic [7:0]  FLAG_FOOTER   = 8'h10;
    localparam logic [7:0]  FLAG_OTHER    = 8'h0f;
    localparam logic [7:0]  ENC_MAX       = 8'h03;

    localparam logic [31:0] FRAME_IDS [NTYPES] = '{
        "TIT1", "TIT2", "TIT3", "TALB", "TRCK", "TPOS", "TSRC",
        "TPE1", "TPE2", "TCOM", "TENC", "TBPM", "TCON", "TCOP",
        "TDRC", "TSSE", "TSOA", "TSOP", "TSOT"
    };

    // m_tdata: frame_type, frame_len, text_encoding, payload_byte, error_code,
    // tag_size, revision
    localparam int OUT_FIELD_BITS = TYPE_W + SIZE_BITS + 2 + 8 + 4 + SIZE_BITS + 8;
    localparam int OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W    = 4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FHDR,
        PH_ENC,
        PH_TEXT,
        PH_PAD,
        PH_STOP
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER      = 3'd0,
        KIND_FRAME_START = 3'd1,
        KIND_PAYLOAD     = 3'd2,
        KIND_TAG_END     = 3'd3,
        KIND_ERROR       = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ERR_EOF,
        ERR_MAGIC,
        ERR_VERSION,
        ERR_UNSYNC,
        ERR_EXTHDR,
        ERR_EXPERIMENTAL,
        ERR_FOOTER,
        ERR_FLAGS,
        ERR_TAGSIZE_BIT,
        ERR_FRAME_ID,
        ERR_FRAMESIZE_BIT,
        ERR_FRAME_FLAGS,
        ERR_OVERSIZE,
        ERR_SHORT,
        ERR_ENCODING,
        ERR_JUNK
    } err_t;

    typedef struct packed {
        kind_t                 kind;
        logic [TYPE_W-1:0]     frame_type;
        logic [SIZE_BITS-1:0]  frame_len;
        logic [1:0]            text_encoding;
        logic [7:0]            payload_byte;
        logic                  last_of_frame;
        err_t                  error_code;
        logic [SIZE_BITS-1:0]  tag_size;
        logic [7:0]            revision;
        logic                  last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } res_pair_t;

    typedef struct packed {
        logic              hit;
        logic [TYPE_W-1:0] idx;
    } id_match_t;

    function automatic id_match_t frame_id_lookup(input logic [31:0] id);
        id_match_t m;
        m = '0;
        for (int i = NTYPES - 1; i >= 0; i--) begin
            if (id == FRAME_IDS[i]) begin
                m.hit = 1'b1;
                m.idx = TYPE_W'(i);
            end
        end
        return m;
    endfunction

endpackage

@@ rtl/core/id3w_parser.sv @@
// id3w_parser: walker state and per-byte decode, up to two results per byte
// depends on id3w_pkg
module id3w_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           data_byte,
    input  logic                 starts_file,
    input  logic                 ends_file,
    output id3w_pkg::res_pair_t  res
);
    import id3w_pkg::*;

    localparam logic [3:0] HDR_LAST = 4'(HDR_LEN - 1);

    phase_t                phase_reg, phase_next;
    logic [3:0]            pos_reg, pos_next;
    logic [SIZE_BITS-1:0]  size_reg, size_next;
    logic [SIZE_BITS-1:0]  tag_reg, tag_next;
    logic [SIZE_BITS-1:0]  frame_reg, frame_next;
    logic [23:0]           id_reg, id_next;
    logic [TYPE_W-1:0]     type_reg, type_next;
    logic [1:0]            enc_reg, enc_next;
    logic [7:0]            rev_reg, rev_next;

    phase_t                ph_e;
    logic [3:0]            pos_e;
    logic [SIZE_BITS-1:0]  sz_e, tag_e, fr_e;
    logic [23:0]           id_e;
    logic [TYPE_W-1:0]     typ_e;
    logic [1:0]            enc_e;
    logic [7:0]            rev_e;

    logic [SIZE_BITS-1:0]  tag_dec, fr_dec, size_sh;
    logic                  pad_start;
    id_match_t             id_m;

    logic  err, hdr_ok, enc_ok, text_byte, lof, tag_end, fhdr_done, pad_path, eof_err;
    err_t  err_code;
    result_t rp, rs;

    // starts_file restarts from the reset state
    assign ph_e  = starts_file ? PH_HEADER : phase_reg;
    assign pos_e = starts_file ? '0 : pos_reg;
    assign sz_e  = starts_file ? '0 : size_reg;
    assign tag_e = starts_file ? '0 : tag_reg;
    assign fr_e  = starts_file ? '0 : frame_reg;
    assign id_e  = starts_file ? '0 : id_reg;
    assign typ_e = starts_file ? '0 : type_reg;
    assign enc_e = starts_file ? '0 : enc_reg;
    assign rev_e = starts_file ? '0 : rev_reg;

    assign tag_dec   = tag_e - 1'b1;
    assign fr_dec    = fr_e - 1'b1;
    assign size_sh   = {sz_e[SIZE_BITS-8:0], data_byte[6:0]};
    assign pad_start = (pos_e == '0) &&
                       ((tag_e < SIZE_BITS'(HDR_LEN)) || (data_byte == 8'h00));
    assign id_m      = frame_id_lookup({id_e, data_byte});

    always_comb begin
        err       = 1'b0;
        err_code  = ERR_EOF;
        hdr_ok    = 1'b0;
        enc_ok    = 1'b0;
        text_byte = 1'b0;
        lof       = 1'b0;
        tag_end   = 1'b0;
        fhdr_done = 1'b0;
        pad_path  = 1'b0;
        pos_next   = pos_e;
        size_next  = sz_e;
        tag_next   = tag_e;
        frame_next = fr_e;
        id_next    = id_e;
        type_next  = typ_e;
        enc_next   = enc_e;
        rev_next   = rev_e;
        unique case (ph_e)
            PH_HEADER: begin
                pos_next = pos_e + 1'b1;
                if (pos_e == 4'd4) begin
                    rev_next = data_byte;
                end
                if ((pos_e == 4'd0 && data_byte != TAG_MAGIC[23:16]) ||
                    (pos_e == 4'd1 && data_byte != TAG_MAGIC[15:8]) ||
                    (pos_e == 4'd2 && data_byte != TAG_MAGIC[7:0])) begin
                    err = 1'b1; err_code = ERR_MAGIC;
                end else if (pos_e == 4'd3 && data_byte != MAJOR_VERSION) begin
                    err = 1'b1; err_code = ERR_VERSION;
                end else if (pos_e == 4'd5 && (data_byte & FLAG_UNSYNC) != '0) begin
                    err = 1'b1; err_code = ERR_UNSYNC;
                end else if (pos_e == 4'd5 && (data_byte & FLAG_EXTHDR) != '0) begin
                    err = 1'b1; err_code = ERR_EXTHDR;
                end else if (pos_e == 4'd5 && (data_byte & FLAG_EXPER) != '0) begin
                    err = 1'b1; err_code = ERR_EXPERIMENTAL;
                end else if (pos_e == 4'd5 && (data_byte & FLAG_FOOTER) != '0) begin
                    err = 1'b1; err_code = ERR_FOOTER;
                end else if (pos_e == 4'd5 && (data_byte & FLAG_OTHER) != '0) begin
                    err = 1'b1; err_code = ERR_FLAGS;
                end else if (pos_e >= 4'd6 && data_byte[7]) begin
                    err = 1'b1; err_code = ERR_TAGSIZE_BIT;
                end else begin
                    if (pos_e >= 4'd6) begin
                        size_next = size_sh;
                    end
                    if (pos_e == HDR_LAST) begin
                        hdr_ok    = 1'b1;
                        tag_next  = size_sh;
                        pos_next  = '0;
                        size_next = '0;
                        tag_end   = (size_sh == '0);
                    end
                end
            end
            PH_FHDR: begin
                if (pad_start) begin
                    pad_path = 1'b1;
                    if (data_byte != 8'h00) begin
                        err = 1'b1; err_code = ERR_JUNK;
                    end else begin
                        tag_next = tag_dec;
                        tag_end  = (tag_dec == '0);
                    end
                end else begin
                    pos_next = pos_e + 1'b1;
                    tag_next = tag_dec;
                    if (pos_e < 4'd3) begin
                        id_next = {id_e[15:0], data_byte};
                    end else if (pos_e == 4'd3) begin
                        if (!id_m.hit) begin
                            err = 1'b1; err_code = ERR_FRAME_ID;
                        end else begin
                            type_next = id_m.idx;
                            size_next = '0;
                        end
                    end else if (pos_e < 4'd8) begin
                        if (data_byte[7]) begin
                            err = 1'b1; err_code = ERR_FRAMESIZE_BIT;
                        end else begin
                            size_next = size_sh;
                        end
                    end else if (data_byte != 8'h00) begin
                        err = 1'b1; err_code = ERR_FRAME_FLAGS;
                    end else if (pos_e == HDR_LAST) begin
                        if (sz_e > tag_dec) begin
                            err = 1'b1; err_code = ERR_OVERSIZE;
                        end else if (sz_e < SIZE_BITS'(MIN_FRAME_SIZE)) begin
                            err = 1'b1; err_code = ERR_SHORT;
                        end else begin
                            fhdr_done  = 1'b1;
                            frame_next = sz_e;
                            pos_next   = '0;
                        end
                    end
                end
            end
            PH_ENC: begin
                tag_next   = tag_dec;
                frame_next = fr_dec;
                if (data_byte > ENC_MAX) begin
                    err = 1'b1; err_code = ERR_ENCODING;
                end else begin
                    enc_ok   = 1'b1;
                    enc_next = data_byte[1:0];
                end
            end
            PH_TEXT: begin
                tag_next   = tag_dec;
                frame_next = fr_dec;
                text_byte  = 1'b1;
                if (fr_dec == '0) begin
                    lof      = 1'b1;
                    pos_next = '0;
                    tag_end  = (tag_dec == '0);
                end
            end
            PH_PAD: begin
                pad_path = 1'b1;
                if (data_byte != 8'h00) begin
                    err = 1'b1; err_code = ERR_JUNK;
                end else begin
                    tag_next = tag_dec;
                    tag_end  = (tag_dec == '0);
                end
            end
            default: begin
            end
        endcase
        eof_err = ends_file && !err && !tag_end && (ph_e != PH_STOP);
    end

    always_comb begin
        phase_next = ph_e;
        unique case (ph_e)
            PH_HEADER: phase_next = hdr_ok ? PH_FHDR : PH_HEADER;
            PH_FHDR: begin
                if (pad_path) begin
                    phase_next = PH_PAD;
                end else if (fhdr_done) begin
                    phase_next = PH_ENC;
                end
            end
            PH_ENC:  phase_next = PH_TEXT;
            PH_TEXT: phase_next = lof ? PH_FHDR : PH_TEXT;
            PH_PAD:  phase_next = PH_PAD;
            default: phase_next = PH_STOP;
        endcase
        if (err || tag_end || eof_err) begin
            phase_next = PH_STOP;
        end
    end

    always_comb begin
        rp = '0;
        rs = '0;
        priority if (err) begin
            rp.kind       = KIND_ERROR;
            rp.error_code = err_code;
        end else if (hdr_ok) begin
            rp.kind     = KIND_HEADER;
            rp.tag_size = size_sh;
            rp.revision = rev_e;
        end else if (enc_ok) begin
            rp.kind          = KIND_FRAME_START;
            rp.frame_type    = typ_e;
            rp.frame_len     = sz_e;
            rp.text_encoding = data_byte[1:0];
        end else if (text_byte) begin
            rp.kind          = KIND_PAYLOAD;
            rp.frame_type    = typ_e;
            rp.frame_len     = sz_e;
            rp.text_encoding = enc_e;
            rp.payload_byte  = data_byte;
            rp.last_of_frame = lof;
        end else begin
        end
        if (tag_end) begin
            rs.kind = KIND_TAG_END;
        end else begin
            rs.kind       = KIND_ERROR;
            rs.error_code = ERR_EOF;
        end
        rs.last_of_run = 1'b1;
        if (err || hdr_ok || enc_ok || text_byte) begin
            rp.last_of_run = !(tag_end || eof_err);
            res.r0 = rp;
            res.r1 = rs;
            res.n  = (tag_end || eof_err) ? 2'd2 : 2'd1;
        end else begin
            res.r0 = rs;
            res.r1 = rs;
            res.n  = (tag_end || eof_err) ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            size_reg  <= '0;
            tag_reg   <= '0;
            frame_reg <= '0;
            id_reg    <= '0;
            type_reg  <= '0;
            enc_reg   <= '0;
            rev_reg   <= '0;
        end else if (in_valid) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            size_reg  <= size_next;
            tag_reg   <= tag_next;
            frame_reg <= frame_next;
            id_reg    <= id_next;
            type_reg  <= type_next;
            enc_reg   <= enc_next;
            rev_reg   <= rev_next;
        end
    end

endmodule

@@ rtl/core/id3w_fifo.sv @@
// id3w_fifo: small result queue, takes up to two results per cycle, gives one
// depends on id3w_pkg
module id3w_fifo #(
    parameter int DEPTH = id3w_pkg::RES_FIFO_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  id3w_pkg::res_pair_t  wr,
    output logic                 space_ok,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output id3w_pkg::result_t    rd_data
);
    import id3w_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next, wptr1, rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         push_n;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_n   = wr_en ? wr.n : 2'd0;
    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rptr_reg];
    assign space_ok = (count_reg <= CNT_W'(DEPTH - 2));
    assign wptr1    = ptr_inc(wptr_reg);

    always_comb begin
        unique case (push_n)
            2'd1:    wptr_next = wptr1;
            2'd2:    wptr_next = ptr_inc(wptr1);
            default: wptr_next = wptr_reg;
        endcase
        rptr_next  = pop ? ptr_inc(rptr_reg) : rptr_reg;
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wptr_reg] <= wr.r0;
        end
        if (push_n == 2'd2) begin
            mem[wptr1] <= wr.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/id3v24_tag_frame_walker_unit.sv @@
// id3v24_tag_frame_walker_unit: top level of the id3v2.4 tag header and frame walker
// depends on id3w_pkg, id3w_parser, id3w_fifo
//
// Usage:
//   s_ channel: one file byte per transfer in s_tdata[7:0]; s_tuser marks the
//   first byte of a file and restarts the walk; s_tlast marks the last byte.
//   m_ channel: results; m_tuser holds the result kind and the last-of-frame
//   flag, m_tdata the frame, error and header fields; m_tlast marks the final
//   result caused by one input byte (a byte causes zero, one or two results).
// Timing:
//   a byte is decoded in the cycle it is accepted; its results are written to a
//   FIFO_DEPTH-entry (four by default) result queue and show on m_ from its head.
//   one byte per cycle is accepted while the queue has room for two results;
//   the m_ side drains one result per cycle while m_tready is high, so a byte
//   with two results leaves the queue as two transfers.
// Reset: aresetn clears the walk state and empties the result queue.
// Stall: with m_tready low the queue fills and s_tready drops once fewer than
//   two free entries remain; no result is lost or reordered.
module id3v24_tag_frame_walker_unit #(
    parameter int FIFO_DEPTH = id3w_pkg::RES_FIFO_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // data_byte
    input  logic                                s_tuser,   // starts_file
    input  logic                                s_tlast,   // ends_file
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // frame_type, frame_len, text_encoding, payload_byte, error_code, tag_size,
    // revision, zero fill
    output logic [id3w_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [id3w_pkg::OUT_TUSER_W-1:0]    m_tuser,   // kind, last_of_frame
    output logic                                m_tlast    // last_of_run
);
    import id3w_pkg::*;

    logic      accept;
    res_pair_t res;
    result_t   head;

    assign accept = s_tvalid && s_tready;

    id3w_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (accept),
        .data_byte   (s_tdata),
        .starts_file (s_tuser),
        .ends_file   (s_tlast),
        .res         (res)
    );

    id3w_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (accept),
        .wr       (res),
        .space_ok (s_tready),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (head)
    );

    assign m_tdata = {{(OUT_TDATA_W - OUT_FIELD_BITS){1'b0}},
                      head.revision, head.tag_size, head.error_code,
                      head.payload_byte, head.text_encoding, head.frame_len,
                      head.frame_type};
    assign m_tuser = {head.last_of_frame, head.kind};
    assign m_tlast = head.last_of_run;

endmodule

@@ rtl/core/id3w_checker.sv @@
// id3w_checker: port-level assertions for id3v24_tag_frame_walker_unit
// depends on id3w_pkg; bound to the top level below
module id3w_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [id3w_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic [id3w_pkg::OUT_TUSER_W-1:0]    m_tuser,
    input  logic                                m_tlast
);

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // second result of a byte is already queued
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("result run broken");

    // input only stalls while results wait
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid)
        else $error("input stalled with empty queue");

endmodule

bind id3v24_tag_frame_walker_unit id3w_checker u_id3w_checker (.*);

@@ test/id3v24_tag_frame_walker_unit_tb.sv @@
// self-checking testbench for id3v24_tag_frame_walker_unit: feeds tag files byte by byte,
// predicts header, frame, payload, tag end and error results, checks every m_ transfer
// depends on id3w_pkg and the walker rtl
`timescale 1ns / 100ps

module id3v24_tag_frame_walker_unit_tb;
    import id3w_pkg::*;

    localparam int FT_LO = 0;
    localparam int FS_LO = FT_LO + TYPE_W;
    localparam int TE_LO = FS_LO + SIZE_BITS;
    localparam int PB_LO = TE_LO + 2;
    localparam int EC_LO = PB_LO + 8;
    localparam int TS_LO = EC_LO + 4;
    localparam int RV_LO = TS_LO + SIZE_BITS;
    localparam int NUM_ITEMS = 750;

    typedef struct packed {
        logic [7:0] b;
        logic       first;
        logic       last;
    } file_byte_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    file_byte_t  pending[$];
    logic [7:0]  fbuf[$];
    result_t     want_q[$];
    result_t     run_buf[2];
    int          run_n;

    // walker state mirror
    phase_t          ph;
    logic [3:0]      pos;
    logic [27:0]     sz_acc;
    logic [27:0]     tag_left;
    logic [27:0]     frm_left;
    logic [23:0]     id_acc;
    logic [4:0]      cur_type;
    logic [1:0]      cur_enc;
    logic [7:0]      hdr_rev;

    int  n_sent = 0;
    int  n_files = 0;
    int  n_results = 0;
    int  n_frames = 0;
    int  n_errors = 0;
    int  n_tag_ends = 0;
    int  fails = 0;
    bit  quiet;
    file_byte_t cur;
    result_t    got;
    result_t    want;

    string field_name [10] = '{"kind", "frame_type", "frame_len", "text_encoding",
        "payload_byte", "last_of_frame", "error_code", "tag_size", "revision",
        "last_of_run"};

    id3v24_tag_frame_walker_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    assign quiet = (n_sent >= 300) && (n_sent < 420);

    function automatic void clear_walk();
        ph = PH_HEADER;
        pos = '0;
        sz_acc = '0;
        tag_left = '0;
        frm_left = '0;
        id_acc = '0;
        cur_type = '0;
        cur_enc = '0;
        hdr_rev = '0;
    endfunction

    function automatic void add_res(kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        if (k == KIND_FRAME_START || k == KIND_PAYLOAD) begin
            r.frame_type = cur_type;
            r.frame_len = sz_acc;
            r.text_encoding = cur_enc;
        end
        run_buf[run_n] = r;
        run_n++;
    endfunction

    function automatic void add_err(err_t e);
        add_res(KIND_ERROR);
        run_buf[run_n-1].error_code = e;
        ph = PH_STOP;
    endfunction

    function automatic void tag_end_check();
        if (tag_left == 0) begin
            add_res(KIND_TAG_END);
            ph = PH_STOP;
        end
    endfunction

    function automatic void pad_byte(logic [7:0] b);
        if (b != 0) begin
            add_err(ERR_JUNK);
            return;
        end
        tag_left = tag_left - 28'd1;
        tag_end_check();
    endfunction

    function automatic void hdr_byte(logic [7:0] b);
        logic [3:0] p;
        p = pos;
        pos = p + 4'd1;
        if (p < 3 && b != TAG_MAGIC[8*(2-p) +: 8]) begin
            add_err(ERR_MAGIC);
            return;
        end
        if (p == 3 && b != MAJOR_VERSION) begin
            add_err(ERR_VERSION);
            return;
        end
        if (p == 4)
            hdr_rev = b;
        if (p == 5) begin
            if ((b & FLAG_UNSYNC) != 0) begin
                add_err(ERR_UNSYNC);
                return;
            end
            if ((b & FLAG_EXTHDR) != 0) begin
                add_err(ERR_EXTHDR);
                return;
            end
            if ((b & FLAG_EXPER) != 0) begin
                add_err(ERR_EXPERIMENTAL);
                return;
            end
            if ((b & FLAG_FOOTER) != 0) begin
                add_err(ERR_FOOTER);
                return;
            end
            if ((b & FLAG_OTHER) != 0) begin
                add_err(ERR_FLAGS);
                return;
            end
        end
        if (p >= 6) begin
            if (b[7]) begin
                add_err(ERR_TAGSIZE_BIT);
                return;
            end
            sz_acc = {sz_acc[20:0], b[6:0]};
        end
        if (p == HDR_LEN - 1) begin
            tag_left = sz_acc;
            add_res(KIND_HEADER);
            run_buf[run_n-1].tag_size = tag_left;
            run_buf[run_n-1].revision = hdr_rev;
            ph = PH_FHDR;
            pos = '0;
            sz_acc = '0;
            tag_end_check();
        end
    endfunction

    function automatic void fhdr_byte(logic [7:0] b);
        logic [3:0]  p;
        logic [31:0] id;
        bit          hit;
        int          i;
        p = pos;
        if (p == 0 && (tag_left < HDR_LEN || b == 0)) begin
            ph = PH_PAD;
            pad_byte(b);
            return;
        end
        pos = p + 4'd1;
        tag_left = tag_left - 28'd1;
        if (p < 3) begin
            id_acc = {id_acc[15:0], b};
        end else if (p == 3) begin
            id = {id_acc, b};
            hit = 1'b0;
            for (i = 0; i < NTYPES; i++) begin
                if (!hit && FRAME_IDS[i] == id) begin
                    cur_type = 5'(i);
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                add_err(ERR_FRAME_ID);
                return;
            end
            sz_acc = '0;
        end else if (p < 8) begin
            if (b[7]) begin
                add_err(ERR_FRAMESIZE_BIT);
                return;
            end
            sz_acc = {sz_acc[20:0], b[6:0]};
        end else begin
            if (b != 0) begin
                add_err(ERR_FRAME_FLAGS);
                return;
            end
            if (p == HDR_LEN - 1) begin
                if (sz_acc > tag_left) begin
                    add_err(ERR_OVERSIZE);
                    return;
                end
                if (sz_acc < MIN_FRAME_SIZE) begin
                    add_err(ERR_SHORT);
                    return;
                end
                frm_left = sz_acc;
                ph = PH_ENC;
                pos = '0;
            end
        end
    endfunction

    // expected results of one accepted byte, appended to want_q
    function automatic void walk_byte(logic [7:0] b, logic first, logic last);
        int i;
        run_n = 0;
        if (first)
            clear_walk();
        case (ph)
            PH_HEADER: hdr_byte(b);
            PH_FHDR:   fhdr_byte(b);
            PH_ENC: begin
                tag_left = tag_left - 28'd1;
                frm_left = frm_left - 28'd1;
                if (b > ENC_MAX) begin
                    add_err(ERR_ENCODING);
                end else begin
                    cur_enc = b[1:0];
                    add_res(KIND_FRAME_START);
                    ph = PH_TEXT;
                end
            end
            PH_TEXT: begin
                tag_left = tag_left - 28'd1;
                frm_left = frm_left - 28'd1;
                add_res(KIND_PAYLOAD);
                run_buf[run_n-1].payload_byte = b;
                if (frm_left == 0) begin
                    run_buf[run_n-1].last_of_frame = 1'b1;
                    ph = PH_FHDR;
                    pos = '0;
                    tag_end_check();
                end
            end
            PH_PAD:    pad_byte(b);
            default:   return;
        endcase
        if (last && ph != PH_STOP)
            add_err(ERR_EOF);
        if (run_n > 0)
            run_buf[run_n-1].last_of_run = 1'b1;
        for (i = 0; i < run_n; i++)
            want_q.push_back(run_buf[i]);
    endfunction

    function automatic logic [27:0] field_val(result_t r, int i);
        case (i)
            0:       return 28'(r.kind);
            1:       return 28'(r.frame_type);
            2:       return r.frame_len;
            3:       return 28'(r.text_encoding);
            4:       return 28'(r.payload_byte);
            5:       return 28'(r.last_of_frame);
            6:       return 28'(r.error_code);
            7:       return r.tag_size;
            8:       return 28'(r.revision);
            default: return 28'(r.last_of_run);
        endcase
    endfunction

    // stimulus driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            s_tlast <= 1'b0;
            clear_walk();
        end else begin
            if (s_tvalid && s_tready) begin
                walk_byte(s_tdata, s_tuser, s_tlast);
                n_sent <= n_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending.size() != 0 && (quiet || $urandom_range(99) >= 37)) begin
                    cur = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur.b;
                    s_tuser <= cur.first;
                    s_tlast <= cur.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 37);
            if (m_tvalid && m_tready) begin
                n_results++;
                got.kind = kind_t'(m_tuser[2:0]);
                got.last_of_frame = m_tuser[3];
                got.frame_type = m_tdata[FT_LO +: TYPE_W];
                got.frame_len = m_tdata[FS_LO +: SIZE_BITS];
                got.text_encoding = m_tdata[TE_LO +: 2];
                got.payload_byte = m_tdata[PB_LO +: 8];
                got.error_code = err_t'(m_tdata[EC_LO +: 4]);
                got.tag_size = m_tdata[TS_LO +: SIZE_BITS];
                got.revision = m_tdata[RV_LO +: 8];
                got.last_of_run = m_tlast;
                case (got.kind)
                    KIND_FRAME_START: n_frames++;
                    KIND_TAG_END:     n_tag_ends++;
                    KIND_ERROR:       n_errors++;
                    default: ;
                endcase
                if (want_q.size() == 0) begin
                    $error("result with no expected transfer pending, kind %0d", got.kind);
                    fails++;
                end else begin
                    want = want_q.pop_front();
                    for (int i = 0; i < 10; i++) begin
                        if (field_val(got, i) !== field_val(want, i)) begin
                            $error("%s: expected %0h, got %0h", field_name[i],
                                field_val(want, i), field_val(got, i));
                            fails++;
                        end
                    end
                end
            end
        end
    end

    task automatic put_sync(int v);
        logic [27:0] s;
        s = 28'(v);
        fbuf.push_back({1'b0, s[27:21]});
        fbuf.push_back({1'b0, s[20:14]});
        fbuf.push_back({1'b0, s[13:7]});
        fbuf.push_back({1'b0, s[6:0]});
    endtask

    task automatic put_hdr(int rev, logic [7:0] flags, int size);
        fbuf.push_back(TAG_MAGIC[23:16]);
        fbuf.push_back(TAG_MAGIC[15:8]);
        fbuf.push_back(TAG_MAGIC[7:0]);
        fbuf.push_back(MAJOR_VERSION);
        fbuf.push_back(8'(rev));
        fbuf.push_back(flags);
        put_sync(size);
    endtask

    task automatic put_frame(int idx, int size, logic [7:0] enc, int ntext);
        logic [31:0] id;
        id = FRAME_IDS[idx];
        fbuf.push_back(id[31:24]);
        fbuf.push_back(id[23:16]);
        fbuf.push_back(id[15:8]);
        fbuf.push_back(id[7:0]);
        put_sync(size);
        fbuf.push_back(8'h00);
        fbuf.push_back(8'h00);
        fbuf.push_back(enc);
        repeat (ntext) fbuf.push_back(8'($urandom));
    endtask

    // well-formed tag: header, frames with random text, zero padding
    task automatic build_tag(int nfr, int npad);
        int len[4];
        int total;
        int i;
        total = npad;
        for (i = 0; i < nfr; i++) begin
            len[i] = $urandom_range(1, 6);
            total += HDR_LEN + 1 + len[i];
        end
        put_hdr($urandom_range(0, 255), 8'h00, total);
        for (i = 0; i < nfr; i++)
            put_frame($urandom_range(0, NTYPES - 1), len[i] + 1, 8'($urandom_range(0, 3)),
                len[i]);
        repeat (npad) fbuf.push_back(8'h00);
    endtask

    // move the first keep bytes of fbuf (all when keep <= 0) to the pending queue
    task automatic ship(bit mark, int keep, int end_at);
        int n;
        int i;
        file_byte_t it;
        n = (keep > 0 && keep < fbuf.size()) ? keep : fbuf.size();
        for (i = 0; i < n; i++) begin
            it.b = fbuf[i];
            it.first = mark && (i == 0);
            it.last = (i == end_at);
            pending.push_back(it);
        end
        if (mark)
            n_files++;
        fbuf.delete();
    endtask

    initial begin
        int k;
        int sel;
        int endr;

        // empty tag, first byte without a start mark, top revision
        put_hdr(255, 8'h00, 0);
        ship(1'b0, 0, -1);
        // bad magic at each position
        for (k = 0; k < 3; k++) begin
            put_hdr(0, 8'h00, 0);
            fbuf[k] = fbuf[k] ^ 8'h01;
            ship(1'b1, k + 1, -1);
        end
        put_hdr(0, 8'h00, 0);
        fbuf[3] = 8'h03;
        ship(1'b1, 4, -1);
        put_hdr(0, FLAG_UNSYNC, 0);
        ship(1'b1, 6, -1);
        put_hdr(0, FLAG_EXTHDR, 0);
        ship(1'b1, 6, -1);
        put_hdr(0, FLAG_EXPER, 0);
        ship(1'b1, 6, -1);
        put_hdr(0, FLAG_FOOTER, 0);
        ship(1'b1, 6, -1);
        put_hdr(0, FLAG_OTHER, 0);
        ship(1'b1, 6, -1);
        put_hdr(0, 8'h00, 0);
        fbuf[7] = 8'h80;
        ship(1'b1, 8, -1);
        // largest tag size, file ends inside the tag
        put_hdr(1, 8'h00, 28'hFFFFFFF);
        put_frame(NTYPES - 1, 3, 8'h03, 2);
        ship(1'b1, 0, fbuf.size() - 1);
        // largest frame size does not fit
        put_hdr(0, 8'h00, 20);
        put_frame(0, 28'hFFFFFFF, 8'h00, 0);
        ship(1'b1, 20, -1);
        // frames too short for an encoding byte plus text
        put_hdr(0, 8'h00, 20);
        put_frame(1, 1, 8'h00, 0);
        ship(1'b1, 20, -1);
        put_hdr(0, 8'h00, 20);
        put_frame(2, 0, 8'h00, 0);
        ship(1'b1, 20, -1);
        // unknown id, size bit, frame flags, bad encoding
        put_hdr(0, 8'h00, 20);
        put_frame(3, 4, 8'h00, 3);
        fbuf[13] = 8'h58;
        ship(1'b1, 14, -1);
        put_hdr(0, 8'h00, 20);
        put_frame(3, 4, 8'h00, 3);
        fbuf[15] = fbuf[15] | 8'h80;
        ship(1'b1, 16, -1);
        put_hdr(0, 8'h00, 20);
        put_frame(3, 4, 8'h00, 3);
        fbuf[18] = 8'h40;
        ship(1'b1, 19, -1);
        put_hdr(0, 8'h00, 20);
        put_frame(4, 4, 8'hFF, 3);
        ship(1'b1, 21, -1);
        // zero padding starting with a zero byte, ends exactly with the file
        put_hdr(7, 8'h00, 30);
        put_frame(5, 5, 8'h01, 4);
        repeat (15) fbuf.push_back(8'h00);
        ship(1'b1, 0, fbuf.size() - 1);
        // junk inside padding
        put_hdr(7, 8'h00, 30);
        put_frame(6, 5, 8'h02, 4);
        repeat (15) fbuf.push_back(8'h00);
        fbuf[fbuf.size() - 2] = 8'hA5;
        ship(1'b1, 0, -1);
        // fewer than a frame header left, then bytes past the tag
        put_hdr(0, 8'h00, 20);
        put_frame(7, 5, 8'h03, 4);
        repeat (5) fbuf.push_back(8'h00);
        fbuf.push_back(8'hFF);
        fbuf.push_back(8'h33);
        ship(1'b1, 0, -1);
        put_hdr(0, 8'h00, 20);
        put_frame(8, 5, 8'h00, 4);
        fbuf.push_back(8'h01);
        ship(1'b1, 0, -1);
        // file ends in the middle of the text
        put_hdr(0, 8'h00, 60);
        put_frame(9, 7, 8'h03, 6);
        ship(1'b1, 0, 22);
        // restart in the middle of a frame header
        put_hdr(0, 8'h00, 60);
        put_frame(10, 7, 8'h00, 6);
        ship(1'b1, 14, -1);

        while (pending.size() < NUM_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                build_tag($urandom_range(0, 3),
                    ($urandom_range(3) == 0) ? $urandom_range(1, 12) : 0);
                repeat ($urandom_range(0, 2)) fbuf.push_back(8'($urandom));
                if ($urandom_range(99) < 30)
                    fbuf[$urandom_range(0, fbuf.size() - 1)] = 8'($urandom);
            end else if (sel < 85) begin
                put_hdr($urandom_range(0, 255),
                    ($urandom_range(1) == 0) ? 8'h00 : 8'(1 << $urandom_range(0, 7)),
                    $urandom_range(0, 40));
                fbuf[$urandom_range(0, fbuf.size() - 1)] = 8'($urandom);
            end else begin
                repeat ($urandom_range(1, 12)) fbuf.push_back(8'($urandom));
            end
            endr = $urandom_range(99);
            ship($urandom_range(99) < 92, 0,
                (endr < 15) ? $urandom_range(0, fbuf.size() - 1) :
                (endr < 80) ? fbuf.size() - 1 : -1);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid) @(posedge aclk);
        while (want_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("walked %0d files in %0d bytes: %0d results checked", n_files, n_sent,
            n_results);
        $display("  %0d frames started, %0d tag ends, %0d errors", n_frames, n_tag_ends,
            n_errors);
        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout waiting for transfers");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
